### hw/rtl/ksmw_pkg.sv
// Shared types and constants for the knapsack max-weight block.
// Holds the microcode word, sequencer steps and the control program ROM.
// No dependencies; used by the sequencer, the datapath and the top.
package ksmw_pkg;

    // Fixed field widths
    localparam int WEIGHT_W    = 16;
    localparam int CAP_W       = 10;
    localparam int OUT_W       = 10;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    // Sequencer step addresses
    typedef enum logic [2:0] {
        ST_CLR_INIT = 3'd0,
        ST_CLR_LOOP = 3'd1,
        ST_WAIT     = 3'd2,
        ST_CHECK    = 3'd3,
        ST_WALK     = 3'd4,
        ST_DRAIN    = 3'd5,
        ST_FINISH   = 3'd6,
        ST_EMIT     = 3'd7
    } step_t;

    // Jump conditions: jump to target when true, else fall through
    typedef enum logic [2:0] {
        COND_NEXT,
        COND_NO_ACCEPT,
        COND_SKIP,
        COND_C_NONZERO,
        COND_C_ABOVE_W,
        COND_NOT_LAST,
        COND_OUT_BUSY
    } cond_t;

    // One control word
    typedef struct packed {
        logic  in_ready;
        logic  clr_we;
        logic  walk_rd;
        logic  rd_cap;
        logic  out_load;
        logic  c_load_max;
        logic  c_dec;
        cond_t cond;
        step_t target;
    } ucode_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic accept;
        logic skip;
        logic c_zero;
        logic c_at_w;
        logic last;
        logic out_busy;
    } stat_t;

    // Control program
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        w = '{in_ready: 1'b0, clr_we: 1'b0, walk_rd: 1'b0, rd_cap: 1'b0,
              out_load: 1'b0, c_load_max: 1'b0, c_dec: 1'b0,
              cond: COND_NEXT, target: ST_CLR_INIT};
        case (step)
            ST_CLR_INIT: begin
                w.c_load_max = 1'b1;
            end
            ST_CLR_LOOP: begin
                w.clr_we = 1'b1;
                w.c_dec  = 1'b1;
                w.cond   = COND_C_NONZERO;
                w.target = ST_CLR_LOOP;
            end
            ST_WAIT: begin
                w.in_ready = 1'b1;
                w.cond     = COND_NO_ACCEPT;
                w.target   = ST_WAIT;
            end
            ST_CHECK: begin
                w.c_load_max = 1'b1;
                w.cond       = COND_SKIP;
                w.target     = ST_FINISH;
            end
            ST_WALK: begin
                w.walk_rd = 1'b1;
                w.c_dec   = 1'b1;
                w.cond    = COND_C_ABOVE_W;
                w.target  = ST_WALK;
            end
            ST_DRAIN: begin
                w.cond = COND_NEXT;
            end
            ST_FINISH: begin
                w.rd_cap = 1'b1;
                w.cond   = COND_NOT_LAST;
                w.target = ST_WAIT;
            end
            ST_EMIT: begin
                w.out_load = 1'b1;
                w.cond     = COND_OUT_BUSY;
                w.target   = ST_FINISH;
            end
            default: begin
                w.cond = COND_NEXT;
            end
        endcase
        return w;
    endfunction

endpackage

### hw/rtl/ksmw_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module ksmw_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### hw/rtl/ksmw_useq.sv
// Microcoded sequencer: step counter, control ROM and jump logic.
// Depends on ksmw_pkg.
module ksmw_useq (
    input  logic            clk,
    input  logic            rst_n,
    input  ksmw_pkg::stat_t stat,
    output ksmw_pkg::ucode_t uc
);

    ksmw_pkg::step_t pc_reg;
    ksmw_pkg::step_t pc_next;
    logic            jump;

    // Hold the step counter; reset starts the table clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= ksmw_pkg::ST_CLR_INIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    // Fetch the control word and pick the next step
    always_comb
    begin
        uc = ksmw_pkg::ucode_rom(pc_reg);
        case (uc.cond)
            ksmw_pkg::COND_NEXT:      jump = 1'b0;
            ksmw_pkg::COND_NO_ACCEPT: jump = !stat.accept;
            ksmw_pkg::COND_SKIP:      jump = stat.skip;
            ksmw_pkg::COND_C_NONZERO: jump = !stat.c_zero;
            ksmw_pkg::COND_C_ABOVE_W: jump = !stat.c_at_w;
            ksmw_pkg::COND_NOT_LAST:  jump = !stat.last;
            ksmw_pkg::COND_OUT_BUSY:  jump = stat.out_busy;
            default:                  jump = 1'b0;
        endcase
        pc_next = jump ? uc.target : ksmw_pkg::step_t'(pc_reg + 3'd1);
    end

endmodule

### hw/rtl/ksmw_dpath.sv
// Datapath: capacity counter, item registers, best-weight table, update
// compare and output register. Depends on ksmw_pkg and ksmw_ram.
module ksmw_dpath #(
    parameter int MAX_CAPACITY = 1023
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ksmw_pkg::ucode_t                    uc,
    output ksmw_pkg::stat_t                     stat,
    input  logic                                in_valid,
    input  logic [ksmw_pkg::WEIGHT_W-1:0]       in_weight,
    input  logic                                in_last,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [ksmw_pkg::OUT_W-1:0]          out_data,
    input  logic                                cfg_valid,
    input  logic [ksmw_pkg::CAP_W-1:0]          cfg_data
);

    localparam int AW = $clog2(MAX_CAPACITY + 1);
    localparam int OW = ksmw_pkg::OUT_W;
    localparam logic [AW-1:0] C_MAX = AW'(MAX_CAPACITY);

    logic [ksmw_pkg::CAP_W-1:0]    cap_reg;
    logic [AW-1:0]                 cap_item_reg;
    logic [AW-1:0]                 cap_sat;
    logic [AW-1:0]                 c_reg;
    logic [ksmw_pkg::WEIGHT_W-1:0] w_reg;
    logic                          last_reg;
    logic                          wr_pend_reg;
    logic [AW-1:0]                 c_pend_reg;
    logic                          out_valid_reg;
    logic [OW-1:0]                 out_data_reg;

    logic          accept;
    logic          out_busy;
    logic [AW-1:0] w_low;
    logic [AW:0]   cand;
    logic          upd;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr_a;
    logic [AW-1:0] ram_raddr_b;
    logic [AW-1:0] rd_a;
    logic [AW-1:0] rd_b;

    assign accept   = in_valid && uc.in_ready;
    assign out_busy = out_valid_reg && !out_ready;
    assign w_low    = w_reg[AW-1:0];
    assign cap_sat  = (32'(cap_reg) > MAX_CAPACITY) ? C_MAX : AW'(cap_reg);

    // Candidate best[c-w] + w against best[c], compared in the cycle after the registered reads
    assign cand = {1'b0, rd_b} + {1'b0, w_low};
    assign upd  = wr_pend_reg && (cand > {1'b0, rd_a});

    // Table port selection: clearing sweep, walk update, result read
    assign ram_we      = uc.clr_we || upd;
    assign ram_waddr   = uc.clr_we ? c_reg : c_pend_reg;
    assign ram_wdata   = uc.clr_we ? '0 : cand[AW-1:0];
    assign ram_raddr_a = uc.rd_cap ? cap_item_reg : c_reg;
    assign ram_raddr_b = c_reg - w_low;

    ksmw_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_CAPACITY + 1)
    ) u_table (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (rd_a),
        .raddr_b (ram_raddr_b),
        .rdata_b (rd_b)
    );

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= '0;
        end
        else if (cfg_valid)
        begin
            cap_reg <= cfg_data;
        end
    end

    // Latch the item and the capacity it is judged against
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            w_reg        <= in_weight;
            last_reg     <= in_last;
            cap_item_reg <= cap_sat;
        end
    end

    // Walk counter and delayed write address
    always_ff @(posedge clk)
    begin
        if (uc.c_load_max)
        begin
            c_reg <= C_MAX;
        end
        else if (uc.c_dec)
        begin
            c_reg <= c_reg - AW'(1);
        end
        c_pend_reg <= c_reg;
    end

    // Update pipeline flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            wr_pend_reg <= uc.walk_rd;
        end
    end

    // Output register: load on emit, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (uc.out_load && !out_busy)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (uc.out_load && !out_busy)
        begin
            out_data_reg <= OW'(rd_a);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Status for the sequencer
    always_comb
    begin
        stat.accept   = accept;
        stat.skip     = (w_reg == '0) || (32'(w_reg) > MAX_CAPACITY);
        stat.c_zero   = (c_reg == '0);
        stat.c_at_w   = (c_reg == w_low);
        stat.last     = last_reg;
        stat.out_busy = out_busy;
    end

endmodule

### hw/rtl/knapsack_max_weight_dp_top.sv
// Items are taken one at a time: tready drops after an accept and returns once the
// item is done. A weight w in 1..MAX_CAPACITY walks c down from MAX_CAPACITY to w,
// one table entry a cycle, reading best[c] and best[c-w] on the two-read, one-write
// table RAM; a zero or too heavy weight skips the walk. A last item then loads its result
// and runs a clearing pass; the load waits while the output is stalled. Reset (rst_n, async,
// active low) clears control and capacity, then runs the same clearing pass before any item.
module knapsack_max_weight_dp_top #(
    parameter int MAX_CAPACITY = 1023
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [ksmw_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [15:0] item_weight
    input  logic                                 s_axis_tlast,  // last_item
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [ksmw_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // [9:0] best_weight
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ksmw_pkg::CAP_W-1:0]           cfg_data       // capacity
);

    localparam int OTW = ksmw_pkg::OUT_TDATA_W;

    ksmw_pkg::ucode_t                uc;
    ksmw_pkg::stat_t                 stat;
    logic [ksmw_pkg::OUT_W-1:0]      best_weight;

    // Sequencer
    ksmw_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .uc    (uc)
    );

    // Datapath
    ksmw_dpath #(
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .uc        (uc),
        .stat      (stat),
        .in_valid  (s_axis_tvalid),
        .in_weight (s_axis_tdata[ksmw_pkg::WEIGHT_W-1:0]),
        .in_last   (s_axis_tlast),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (best_weight),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data)
    );

    assign s_axis_tready = uc.in_ready;
    assign m_axis_tdata  = OTW'(best_weight);
    assign cfg_ready     = 1'b1;

endmodule

### hw/rtl/ksmw_chk.sv
// Port-level checker for the knapsack max-weight block, bound to the top.
// Depends on knapsack_max_weight_dp_top ports only.
module ksmw_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // A stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // One item at a time: ready drops right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item taken back to back");

    // A new result only appears while the block is busy with an item
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared while waiting for an item");

endmodule

bind knapsack_max_weight_dp_top ksmw_chk u_ksmw_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
